// File: hw/rtl/rcpr_pkg.sv
package rcpr_pkg;

    // Packet format
    localparam logic [7:0]  PKT_MAGIC     = 8'hA5;
    localparam logic [7:0]  PKT_CHECK_XOR = 8'h5A;
    localparam logic [7:0]  FLAGS_ALLOWED = 8'h03;
    localparam logic [15:0] AGE_MAX       = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    // Request kinds (tuser on the slave side)
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef logic [2:0] t_status;

    // Receive status codes
    localparam t_status ST_TICK      = 3'd0;
    localparam t_status ST_VALID     = 3'd1;
    localparam t_status ST_BAD_MAGIC = 3'd2;
    localparam t_status ST_BAD_FLAGS = 3'd3;
    localparam t_status ST_BAD_CHECK = 3'd4;

    typedef struct packed {
        logic [7:0] check;
        logic [7:0] seq;
        logic [7:0] flags;
        logic [7:0] magic;
    } t_pkt;

    typedef struct packed {
        logic [31:0] change_total;
        logic [31:0] timeout_total;
        logic [31:0] invalid_total;
        logic [31:0] valid_total;
        logic [15:0] age;
        logic [7:0]  seq;
        logic        link;
        logic [1:0]  flags;
        t_status     status;
    } t_result;

endpackage

// File: hw/rtl/remote_command_packet_receiver.sv
// Channel   Dir  tdata                                  tuser
// s_axis    in   magic, flags, seq, check (32 bits)     kind (0 packet, 1 tick)
// m_axis    out  flags/link/seq/age/four totals (160)   rx_status (3 bits)
// cfg       in   link timeout in ticks (16 bits)        -
//
// One request per cycle sustained while m_axis_tready is high; a request's result
// reaches m_axis after acceptance through the input register, then the result
// register. The state update for a request is compare and counter logic ahead
// of the result register.
// Synchronous active-low reset; timeout register resets to 500 ticks.
// A stalled master side holds the result; the input register still takes one
// more request, then s_axis_tready drops until the result is taken.
module remote_command_packet_receiver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] magic_byte, [15:8] flags_byte, [23:16] sequence_byte, [31:24] check_byte
    input  logic [31:0]  s_axis_tdata,
    // [0] kind
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] command_on, [1] switch2_on, [3:2] current_flags, [4] link_up,
    // [12:5] last_seq, [28:13] packet_age, [60:29] valid_total,
    // [92:61] invalid_total, [124:93] timeout_total, [156:125] change_total,
    // [159:157] zero
    output logic [159:0] m_axis_tdata,
    // [2:0] rx_status
    output logic [2:0]   m_axis_tuser,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data
);
    import rcpr_pkg::*;

    logic        r_in_valid;
    logic        r_in_kind;
    t_pkt        r_in_pkt;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_timeout;
    logic        adv;
    t_status     status;
    t_result     res;

    // Advance when a request is held and the result register is free or being taken
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    // Timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser;
            r_in_pkt  <= s_axis_tdata;
        end
    end

    rcpr_classify u_classify (
        .i_kind   (r_in_kind),
        .i_pkt    (r_in_pkt),
        .o_status (status)
    );

    rcpr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_kind    (r_in_kind),
        .i_pkt     (r_in_pkt),
        .i_status  (status),
        .i_timeout (r_timeout),
        .o_res     (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    // Output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {3'd0, r_out.change_total, r_out.timeout_total,
                            r_out.invalid_total, r_out.valid_total, r_out.age,
                            r_out.seq, r_out.link, r_out.flags,
                            r_out.flags[1], r_out.flags[0]};

endmodule

// File: hw/rtl/rcpr_classify.sv
module rcpr_classify (
    input  logic             i_kind,
    input  rcpr_pkg::t_pkt   i_pkt,
    output rcpr_pkg::t_status o_status
);
    import rcpr_pkg::*;

    logic [7:0] expect_chk;

    assign expect_chk = PKT_MAGIC ^ i_pkt.flags ^ i_pkt.seq ^ PKT_CHECK_XOR;

    // Ticks come first; else the first failing check wins: magic, then flags, then check byte
    always_comb begin
        priority if (i_kind == KIND_TICK) begin
            o_status = ST_TICK;
        end else if (i_pkt.magic != PKT_MAGIC) begin
            o_status = ST_BAD_MAGIC;
        end else if ((i_pkt.flags & ~FLAGS_ALLOWED) != 8'd0) begin
            o_status = ST_BAD_FLAGS;
        end else if (i_pkt.check != expect_chk) begin
            o_status = ST_BAD_CHECK;
        end else begin
            o_status = ST_VALID;
        end
    end

endmodule

// File: hw/rtl/rcpr_core.sv
module rcpr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_kind,
    input  rcpr_pkg::t_pkt    i_pkt,
    input  rcpr_pkg::t_status i_status,
    input  logic [15:0]       i_timeout,
    output rcpr_pkg::t_result o_res
);
    import rcpr_pkg::*;

    logic        r_link,    n_link;
    logic [1:0]  r_flags,   n_flags;
    logic [7:0]  r_seq,     n_seq;
    logic [15:0] r_age,     n_age;
    logic [31:0] r_valid,   n_valid;
    logic [31:0] r_invalid, n_invalid;
    logic [31:0] r_timeout, n_timeout;
    logic [31:0] r_change,  n_change;

    // Next state for one request
    always_comb begin
        n_link    = r_link;
        n_flags   = r_flags;
        n_seq     = r_seq;
        n_age     = r_age;
        n_valid   = r_valid;
        n_invalid = r_invalid;
        n_timeout = r_timeout;
        n_change  = r_change;

        if (i_kind == KIND_TICK) begin
            if (r_age != AGE_MAX) begin
                n_age = r_age + 16'd1;
            end
        end else if (i_status == ST_VALID) begin
            if (i_pkt.flags[1:0] != r_flags) begin
                n_change = r_change + 32'd1;
            end
            n_flags = i_pkt.flags[1:0];
            n_seq   = i_pkt.seq;
            n_link  = 1'b1;
            n_age   = 16'd0;
            n_valid = r_valid + 32'd1;
        end else begin
            n_invalid = r_invalid + 32'd1;
        end

        // Link timeout, checked after every request
        if (n_link && (n_age >= i_timeout)) begin
            n_link    = 1'b0;
            n_flags   = 2'd0;
            n_timeout = r_timeout + 32'd1;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link    <= 1'b0;
            r_flags   <= 2'd0;
            r_seq     <= 8'd0;
            r_age     <= AGE_MAX;
            r_valid   <= 32'd0;
            r_invalid <= 32'd0;
            r_timeout <= 32'd0;
            r_change  <= 32'd0;
        end else if (i_en) begin
            r_link    <= n_link;
            r_flags   <= n_flags;
            r_seq     <= n_seq;
            r_age     <= n_age;
            r_valid   <= n_valid;
            r_invalid <= n_invalid;
            r_timeout <= n_timeout;
            r_change  <= n_change;
        end
    end

    // Result is the state after this request
    always_comb begin
        o_res.status        = i_status;
        o_res.flags         = n_flags;
        o_res.link          = n_link;
        o_res.seq           = n_seq;
        o_res.age           = n_age;
        o_res.valid_total   = n_valid;
        o_res.invalid_total = n_invalid;
        o_res.timeout_total = n_timeout;
        o_res.change_total  = n_change;
    end

`ifndef SYNTHESIS
    a_flags_need_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_link |-> (r_flags == 2'd0))
        else $error("flags held while link is down");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_kind == KIND_PACKET && i_status == ST_VALID)
        |=> (r_valid == $past(r_valid) + 32'd1) && (r_age == 16'd0))
        else $error("valid packet did not count or clear age");

    a_tick_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_kind == KIND_TICK)
        |=> $stable(r_valid) && $stable(r_invalid) && $stable(r_seq))
        else $error("tick changed packet state");

    a_timeout_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_timeout != n_timeout) |=> !r_link)
        else $error("timeout counted but link still up");
`endif

endmodule
